### hw/rtl/lskv_pkg.sv
// Shared types and codes for the leveled sorted key/value table.
package lskv_pkg;

   localparam logic [2:0] CMD_INSERT   = 3'd0;
   localparam logic [2:0] CMD_LOOKUP   = 3'd1;
   localparam logic [2:0] CMD_UPDATE   = 3'd2;
   localparam logic [2:0] CMD_REMOVE   = 3'd3;
   localparam logic [2:0] CMD_READ_POS = 3'd4;
   localparam logic [2:0] CMD_PICK     = 3'd5;
   localparam logic [2:0] CMD_CLEAR    = 3'd6;

   localparam logic [1:0] STATUS_DONE = 2'd0;
   localparam logic [1:0] STATUS_DUP  = 2'd1;
   localparam logic [1:0] STATUS_MISS = 2'd2;
   localparam logic [1:0] STATUS_FULL = 2'd3;

   typedef enum logic [2:0] {
      OP_INSERT,
      OP_LOOKUP,
      OP_UPDATE,
      OP_REMOVE,
      OP_READ_POS,
      OP_PICK,
      OP_CLEAR,
      OP_NONE
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SRCH,
      S_SCMP,
      S_HCHK,
      S_SHUP,
      S_INSW,
      S_SHDN,
      S_POS,
      S_SUM,
      S_MUL,
      S_SCAN,
      S_PICK
   } state_type;

   typedef struct packed {
      op_type      op;
      logic [3:0]  level;
      logic [31:0] key;
      logic [63:0] value_word;
      logic [9:0]  position;
      logic [15:0] fraction;
      logic [3:0]  level_limit;
   } item_type;

endpackage

### hw/rtl/lskv_front.sv
// Command intake: decodes incoming commands and queues them for the engine.
module lskv_front #(
   parameter int LEVELS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [2:0]         command,
   input  logic [3:0]         level,
   input  logic [31:0]        key,
   input  logic [63:0]        value_word,
   input  logic [9:0]         position,
   input  logic [15:0]        fraction,
   input  logic [3:0]         level_limit,
   output logic               item_valid,
   output lskv_pkg::item_type item,
   input  logic               item_pop
);
   import lskv_pkg::*;

   item_type   ent_ff [2];
   item_type   new_item;
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   // Level-addressed commands on an absent level become no-ops here.
   always_comb begin
      new_item.level       = level;
      new_item.key         = key;
      new_item.value_word  = value_word;
      new_item.position    = position;
      new_item.fraction    = fraction;
      new_item.level_limit = level_limit;
      unique case (command)
         CMD_INSERT:   new_item.op = OP_INSERT;
         CMD_LOOKUP:   new_item.op = OP_LOOKUP;
         CMD_UPDATE:   new_item.op = OP_UPDATE;
         CMD_REMOVE:   new_item.op = OP_REMOVE;
         CMD_READ_POS: new_item.op = OP_READ_POS;
         CMD_PICK:     new_item.op = OP_PICK;
         CMD_CLEAR:    new_item.op = OP_CLEAR;
         default:      new_item.op = OP_NONE;
      endcase
      if (command <= CMD_READ_POS && 32'(level) >= LEVELS) begin
         new_item.op = OP_NONE;
      end
   end

   assign full       = (cnt_ff == 2'd2);
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = ent_ff[rp_ff];
   assign do_push    = push && !full;
   assign do_pop     = item_pop && item_valid;

   always_comb begin
      wp_in  = do_push ? ~wp_ff : wp_ff;
      rp_in  = do_pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         ent_ff[wp_ff] <= new_item;
      end
   end

endmodule

### hw/rtl/lskv_engine.sv
// Command engine: table memories, level counts, search and shift sequencer, result register.
module lskv_engine #(
   parameter int LEVELS        = 16,
   parameter int CAPACITY      = 1024,
   parameter int FRACTION_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  lskv_pkg::item_type cmd_item,
   output logic               cmd_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_out_key,
   output logic [63:0]        rsp_out_value,
   output logic [3:0]         rsp_out_level,
   output logic [14:0]        rsp_entry_total
);
   import lskv_pkg::*;

   localparam int LIW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int SLOTS = LEVELS * CAPACITY;
   localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int TW    = $clog2(SLOTS + 1);
   localparam int PW    = 16 + TW;

   logic [31:0] key_mem [SLOTS];
   logic [63:0] val_mem [SLOTS];
   logic [31:0] krd_ff;
   logic [63:0] vrd_ff;

   logic [CW-1:0] level_count_ff [LEVELS];

   state_type     state_ff, state_in;
   op_type        op_ff, op_in;
   logic [LIW-1:0] lvl_ff, lvl_in, lim_ff, lim_in, i_ff, i_in;
   logic [31:0]   key_ff, key_in;
   logic [63:0]   val_ff, val_in;
   logic [15:0]   frac_ff, frac_in;
   logic [AW-1:0] base_ff, base_in, mv_dst_ff, mv_dst_in;
   logic [CW-1:0] n_ff, n_in, lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in, c_ff, c_in;
   logic [TW-1:0] total_ff, total_in, j_ff, j_in;
   logic          mv_ff, mv_in;

   logic          rsp_valid_ff;
   logic [1:0]    st_ff;
   logic [31:0]   okey_ff;
   logic [63:0]   oval_ff;
   logic [3:0]    olvl_ff;
   logic [14:0]   otot_ff;

   logic [AW-1:0]  rd_addr, mem_addr, idle_base;
   logic           mem_we;
   logic [31:0]    mem_key;
   logic [63:0]    mem_value;
   logic [LIW-1:0] cnt_idx, idle_lvl;
   logic [CW-1:0]  cnt_rd, cnt_wd, mid;
   logic           cnt_we, cnt_clr;
   logic           res_set;
   logic [1:0]     res_status;
   logic [31:0]    res_key;
   logic [63:0]    res_value;
   logic [3:0]     res_level;
   logic [14:0]    res_total;
   logic           do_hit, do_miss;
   logic [PW-1:0]  prod, jw;

   assign cnt_rd    = level_count_ff[cnt_idx];
   assign idle_lvl  = LIW'(cmd_item.level);
   assign idle_base = AW'(int'(idle_lvl) * CAPACITY);
   assign mid       = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign prod      = PW'(frac_ff) * PW'(total_ff);
   assign jw        = prod >> FRACTION_BITS;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      lvl_in    = lvl_ff;
      key_in    = key_ff;
      val_in    = val_ff;
      frac_in   = frac_ff;
      lim_in    = lim_ff;
      base_in   = base_ff;
      n_in      = n_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      c_in      = c_ff;
      i_in      = i_ff;
      total_in  = total_ff;
      j_in      = j_ff;
      mv_in     = 1'b0;
      mv_dst_in = mv_dst_ff;
      rd_addr   = '0;
      cnt_idx   = lvl_ff;
      cnt_we    = 1'b0;
      cnt_wd    = '0;
      cnt_clr   = 1'b0;
      cmd_pop   = 1'b0;
      res_set   = 1'b0;
      res_status = STATUS_MISS;
      res_key   = '0;
      res_value = '0;
      res_level = '0;
      res_total = '0;
      do_hit    = 1'b0;
      do_miss   = 1'b0;
      // A pending shift move writes the word read in the previous cycle.
      mem_we    = mv_ff;
      mem_addr  = mv_dst_ff;
      mem_key   = krd_ff;
      mem_value = vrd_ff;

      unique case (state_ff)
         S_IDLE: begin
            cnt_idx = idle_lvl;
            if (cmd_valid && !rsp_valid_ff) begin
               cmd_pop = 1'b1;
               op_in   = cmd_item.op;
               lvl_in  = idle_lvl;
               key_in  = cmd_item.key;
               val_in  = cmd_item.value_word;
               frac_in = cmd_item.fraction;
               base_in = idle_base;
               n_in    = cnt_rd;
               lo_in   = '0;
               hi_in   = cnt_rd;
               unique case (cmd_item.op)
                  OP_INSERT, OP_LOOKUP, OP_UPDATE, OP_REMOVE: begin
                     state_in = S_SRCH;
                  end
                  OP_READ_POS: begin
                     if (32'(cmd_item.position) < 32'(cnt_rd)) begin
                        rd_addr  = idle_base + AW'(cmd_item.position);
                        state_in = S_POS;
                     end else begin
                        res_set = 1'b1;
                     end
                  end
                  OP_PICK: begin
                     i_in     = '0;
                     total_in = '0;
                     if (32'(cmd_item.level_limit) >= LEVELS - 1) begin
                        lim_in = LIW'(LEVELS - 1);
                     end else begin
                        lim_in = LIW'(cmd_item.level_limit);
                     end
                     state_in = S_SUM;
                  end
                  OP_CLEAR: begin
                     cnt_clr    = 1'b1;
                     res_set    = 1'b1;
                     res_status = STATUS_DONE;
                  end
                  default: begin
                     res_set = 1'b1;
                  end
               endcase
            end
         end
         S_SRCH: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid;
               rd_addr  = base_ff + AW'(mid);
               state_in = S_SCMP;
            end else if (lo_ff < n_ff) begin
               rd_addr  = base_ff + AW'(lo_ff);
               state_in = S_HCHK;
            end else begin
               do_miss = 1'b1;
            end
         end
         S_SCMP: begin
            if ($signed(krd_ff) < $signed(key_ff)) begin
               lo_in = mid_ff + 1'b1;
            end else begin
               hi_in = mid_ff;
            end
            state_in = S_SRCH;
         end
         S_HCHK: begin
            if (krd_ff == key_ff) begin
               do_hit = 1'b1;
            end else begin
               do_miss = 1'b1;
            end
         end
         S_SHUP: begin
            if (c_ff > lo_ff) begin
               rd_addr   = base_ff + AW'(c_ff - 1'b1);
               mv_in     = 1'b1;
               mv_dst_in = base_ff + AW'(c_ff);
               c_in      = c_ff - 1'b1;
            end else begin
               state_in = S_INSW;
            end
         end
         S_INSW: begin
            mem_we     = 1'b1;
            mem_addr   = base_ff + AW'(lo_ff);
            mem_key    = key_ff;
            mem_value  = val_ff;
            cnt_we     = 1'b1;
            cnt_wd     = n_ff + 1'b1;
            res_set    = 1'b1;
            res_status = STATUS_DONE;
         end
         S_SHDN: begin
            if (c_ff + 1'b1 < n_ff) begin
               rd_addr   = base_ff + AW'(c_ff + 1'b1);
               mv_in     = 1'b1;
               mv_dst_in = base_ff + AW'(c_ff);
               c_in      = c_ff + 1'b1;
            end else begin
               cnt_we     = 1'b1;
               cnt_wd     = n_ff - 1'b1;
               res_set    = 1'b1;
               res_status = STATUS_DONE;
            end
         end
         S_POS: begin
            res_set    = 1'b1;
            res_status = STATUS_DONE;
            res_key    = krd_ff;
            res_value  = vrd_ff;
         end
         S_SUM: begin
            cnt_idx  = i_ff;
            total_in = total_ff + TW'(cnt_rd);
            if (i_ff == lim_ff) begin
               state_in = S_MUL;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         S_MUL: begin
            if (total_ff == '0) begin
               res_set   = 1'b1;
               res_total = 15'(total_ff);
            end else begin
               if (jw >= PW'(total_ff)) begin
                  j_in = total_ff - 1'b1;
               end else begin
                  j_in = TW'(jw);
               end
               i_in     = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cnt_idx = i_ff;
            if (TW'(cnt_rd) > j_ff) begin
               rd_addr  = AW'(int'(i_ff) * CAPACITY) + AW'(j_ff);
               state_in = S_PICK;
            end else begin
               j_in = j_ff - TW'(cnt_rd);
               i_in = i_ff + 1'b1;
            end
         end
         S_PICK: begin
            res_set    = 1'b1;
            res_status = STATUS_DONE;
            res_key    = krd_ff;
            res_value  = vrd_ff;
            res_level  = 4'(i_ff);
            res_total  = 15'(total_ff);
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (do_hit) begin
         unique case (op_ff)
            OP_INSERT: begin
               res_set    = 1'b1;
               res_status = STATUS_DUP;
            end
            OP_LOOKUP: begin
               res_set    = 1'b1;
               res_status = STATUS_DONE;
               res_value  = vrd_ff;
            end
            OP_UPDATE: begin
               mem_we     = 1'b1;
               mem_addr   = base_ff + AW'(lo_ff);
               mem_key    = key_ff;
               mem_value  = val_ff;
               res_set    = 1'b1;
               res_status = STATUS_DONE;
            end
            OP_REMOVE: begin
               c_in     = lo_ff;
               state_in = S_SHDN;
            end
            default: begin
               res_set = 1'b1;
            end
         endcase
      end

      if (do_miss) begin
         unique case (op_ff)
            OP_INSERT: begin
               if (n_ff == CW'(CAPACITY)) begin
                  res_set    = 1'b1;
                  res_status = STATUS_FULL;
               end else begin
                  c_in     = n_ff;
                  state_in = S_SHUP;
               end
            end
            OP_REMOVE: begin
               res_set    = 1'b1;
               res_status = STATUS_DUP;
            end
            default: begin
               res_set = 1'b1;
            end
         endcase
      end

      if (res_set) begin
         state_in = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < LEVELS; k++) begin
            level_count_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         mv_ff    <= mv_in;
         if (res_set) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cnt_clr) begin
            for (int k = 0; k < LEVELS; k++) begin
               level_count_ff[k] <= '0;
            end
         end else if (cnt_we) begin
            level_count_ff[lvl_ff] <= cnt_wd;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      lvl_ff    <= lvl_in;
      key_ff    <= key_in;
      val_ff    <= val_in;
      frac_ff   <= frac_in;
      lim_ff    <= lim_in;
      base_ff   <= base_in;
      n_ff      <= n_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      c_ff      <= c_in;
      i_ff      <= i_in;
      total_ff  <= total_in;
      j_ff      <= j_in;
      mv_dst_ff <= mv_dst_in;
      if (res_set) begin
         st_ff   <= res_status;
         okey_ff <= res_key;
         oval_ff <= res_value;
         olvl_ff <= res_level;
         otot_ff <= res_total;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[mem_addr] <= mem_key;
         val_mem[mem_addr] <= mem_value;
      end
      krd_ff <= key_mem[rd_addr];
      vrd_ff <= val_mem[rd_addr];
   end

   assign rsp_empty       = !rsp_valid_ff;
   assign rsp_status      = st_ff;
   assign rsp_out_key     = $signed(okey_ff);
   assign rsp_out_value   = oval_ff;
   assign rsp_out_level   = olvl_ff;
   assign rsp_entry_total = otot_ff;

endmodule

### hw/rtl/leveled_sorted_key_value_table_core.sv
// Top level of the leveled sorted key/value table: command queue in front of the table engine.
//
// The block keeps LEVELS tables of up to CAPACITY unique signed keys in
// ascending order, each key carrying a 64-bit value word, in one key memory
// and one value memory with a single read and a single write port each.
// Commands enter through a two-deep queue, so a new command can be
// transferred in while the engine still works and while a finished result
// waits in the output register to be popped. The engine runs one command at
// a time. A keyed command runs a binary search, each step reading in S_SRCH
// and comparing in S_SCMP, then checks for a hit in S_HCHK; an insert or
// remove then moves every entry behind the key by one place at one entry
// per cycle through the memory port. Read position issues its read and
// answers in S_POS, clear and unused commands answer straight from idle,
// and a global pick totals the level counts up to the limit in S_SUM,
// scales the fraction in S_MUL, skips whole levels in S_SCAN while locating
// the entry and reads it in S_PICK. The memories need no clearing pass
// after reset: only entries below a level's count are ever read.
module leveled_sorted_key_value_table_core #(
   parameter int LEVELS        = 16,
   parameter int CAPACITY      = 1024,
   parameter int FRACTION_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [2:0]         req_command,
   input  logic [3:0]         req_level,
   input  logic signed [31:0] req_key,
   input  logic [63:0]        req_value_word,
   input  logic [9:0]         req_position,
   input  logic [15:0]        req_fraction,
   input  logic [3:0]         req_level_limit,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_out_key,
   output logic [63:0]        rsp_out_value,
   output logic [3:0]         rsp_out_level,
   output logic [14:0]        rsp_entry_total
);
   import lskv_pkg::*;

   // Decoded command handed from the intake queue to the engine.
   item_type item;
   logic     item_valid;
   logic     item_pop;

   // The front end decodes each transfer and parks it until the engine is free.
   lskv_front #(
      .LEVELS(LEVELS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (req_push),
      .full        (req_full),
      .command     (req_command),
      .level       (req_level),
      .key         (req_key),
      .value_word  (req_value_word),
      .position    (req_position),
      .fraction    (req_fraction),
      .level_limit (req_level_limit),
      .item_valid  (item_valid),
      .item        (item),
      .item_pop    (item_pop)
   );

   // The engine owns the tables and produces exactly one result per command.
   lskv_engine #(
      .LEVELS       (LEVELS),
      .CAPACITY     (CAPACITY),
      .FRACTION_BITS(FRACTION_BITS)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (item_valid),
      .cmd_item        (item),
      .cmd_pop         (item_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_status      (rsp_status),
      .rsp_out_key     (rsp_out_key),
      .rsp_out_value   (rsp_out_value),
      .rsp_out_level   (rsp_out_level),
      .rsp_entry_total (rsp_entry_total)
   );

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the leveled sorted key/value table core.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import lskv_pkg::*;

   localparam int NLEV = 16;
   localparam int CAP = 1024;
   localparam logic [2:0] CMD_UNUSED = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic [2:0] req_command = '0;
   logic [3:0] req_level = '0;
   logic signed [31:0] req_key = '0;
   logic [63:0] req_value_word = '0;
   logic [9:0] req_position = '0;
   logic [15:0] req_fraction = '0;
   logic [3:0] req_level_limit = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic [1:0] rsp_status;
   logic signed [31:0] rsp_out_key;
   logic [63:0] rsp_out_value;
   logic [3:0] rsp_out_level;
   logic [14:0] rsp_entry_total;

   leveled_sorted_key_value_table_core uut (.*);

   // One expected response, as the block should present it.
   typedef struct packed {
      logic [1:0] status;
      logic [31:0] okey;
      logic [63:0] oval;
      logic [3:0] olvl;
      logic [14:0] total;
   } answer_type;

   // One command as offered on the request side.
   typedef struct packed {
      logic [2:0] cmd;
      logic [3:0] lvl;
      logic [31:0] key;
      logic [63:0] val;
      logic [9:0] pos;
      logic [15:0] frac;
      logic [3:0] lim;
   } command_type;

   // Shadow copy of the table contents.
   logic [31:0] shadow_key [NLEV][CAP];
   logic [63:0] shadow_val [NLEV][CAP];
   int shadow_count [NLEV];

   answer_type pending_answers[$];
   int mismatches = 0;
   bit quiet = 0;
   bit hold_rsp = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("end of test: mismatches");
      $finish;
   end

   // Lower-bound search: first position whose key is not below the target,
   // compared as signed values.
   function automatic int find_slot(int l, logic signed [31:0] k);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = shadow_count[l];
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if ($signed(shadow_key[l][mid]) < k) lo = mid + 1;
         else hi = mid;
      end
      return lo;
   endfunction

   // Applies one command to the shadow table and returns the answer.
   function automatic answer_type table_apply(command_type c);
      answer_type a;
      int n;
      int p;
      bit hit;
      int limit;
      longint tot;
      longint j;
      a = '0;
      a.status = STATUS_MISS;
      if (c.cmd <= CMD_READ_POS) begin
         n = shadow_count[c.lvl];
         p = find_slot(c.lvl, c.key);
         hit = (p < n) && (shadow_key[c.lvl][p] == c.key);
         case (c.cmd)
            CMD_INSERT: begin
               if (hit) a.status = STATUS_DUP;
               else if (n >= CAP) a.status = STATUS_FULL;
               else begin
                  for (int i = n; i > p; i--) begin
                     shadow_key[c.lvl][i] = shadow_key[c.lvl][i-1];
                     shadow_val[c.lvl][i] = shadow_val[c.lvl][i-1];
                  end
                  shadow_key[c.lvl][p] = c.key;
                  shadow_val[c.lvl][p] = c.val;
                  shadow_count[c.lvl] = n + 1;
                  a.status = STATUS_DONE;
               end
            end
            CMD_LOOKUP: if (hit) begin
               a.oval = shadow_val[c.lvl][p];
               a.status = STATUS_DONE;
            end
            CMD_UPDATE: if (hit) begin
               shadow_val[c.lvl][p] = c.val;
               a.status = STATUS_DONE;
            end
            CMD_REMOVE: begin
               if (hit) begin
                  for (int i = p; i + 1 < n; i++) begin
                     shadow_key[c.lvl][i] = shadow_key[c.lvl][i+1];
                     shadow_val[c.lvl][i] = shadow_val[c.lvl][i+1];
                  end
                  shadow_count[c.lvl] = n - 1;
                  a.status = STATUS_DONE;
               end else a.status = STATUS_DUP;
            end
            default: if (c.pos < n) begin
               a.okey = shadow_key[c.lvl][c.pos];
               a.oval = shadow_val[c.lvl][c.pos];
               a.status = STATUS_DONE;
            end
         endcase
      end else if (c.cmd == CMD_PICK) begin
         limit = c.lim;
         tot = 0;
         for (int i = 0; i <= limit; i++) tot += shadow_count[i];
         a.total = tot[14:0];
         if (tot != 0) begin
            j = (longint'(c.frac) * tot) >>> 16;
            if (j >= tot) j = tot - 1;
            for (int i = 0; i <= limit; i++) begin
               if (shadow_count[i] > j) begin
                  a.okey = shadow_key[i][j];
                  a.oval = shadow_val[i][j];
                  a.olvl = 4'(i);
                  a.status = STATUS_DONE;
                  break;
               end
               j -= shadow_count[i];
            end
         end
      end else if (c.cmd == CMD_CLEAR) begin
         for (int i = 0; i < NLEV; i++) shadow_count[i] = 0;
         a.status = STATUS_DONE;
      end
      return a;
   endfunction

   // Offers one command until it is transferred; the answer is queued at
   // the accepting edge, after the check of any result popped there. The
   // request stays up after the transfer so that the next call, starting at
   // the same falling edge, either offers its command or drops it for idling.
   task automatic send_command(command_type c, bit has_fixed, answer_type fixed);
      answer_type a;
      if (!quiet && ($urandom_range(0, 3) == 0)) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_push <= 1'b1;
      req_command <= c.cmd;
      req_level <= c.lvl;
      req_key <= c.key;
      req_value_word <= c.val;
      req_position <= c.pos;
      req_fraction <= c.frac;
      req_level_limit <= c.lim;
      do @(posedge clock); while (req_full);
      a = table_apply(c);
      if (has_fixed && a != fixed && mismatches < 10)
         $display("directed row disagrees with predictor: cmd %0d", c.cmd);
      pending_answers.push_back(has_fixed ? fixed : a);
      @(negedge clock);
   endtask

   // Result side: random pop bursts, plus a long hold-off on request.
   initial begin
      int gap;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_pop <= 1'b0;
            repeat (3000) @(negedge clock);
            hold_rsp = 0;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
            rsp_pop <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Checks every result at the edge where it is transferred out.
   always @(posedge clock) begin
      answer_type e;
      answer_type got;
      if (!reset && rsp_pop && !rsp_empty) begin
         got = '{rsp_status, rsp_out_key, rsp_out_value, rsp_out_level, rsp_entry_total};
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
         end else begin
            e = pending_answers.pop_front();
            if (got != e) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: expected st %0d key %h val %h lvl %0d tot %0d,",
                            " got st %0d key %h val %h lvl %0d tot %0d"},
                     e.status, e.okey, e.oval, e.olvl, e.total,
                     got.status, got.okey, got.oval, got.olvl, got.total);
            end
         end
      end
   end

   function automatic command_type mk(logic [2:0] cmd, logic [3:0] lvl, logic [31:0] key,
                                      logic [63:0] val, logic [9:0] pos, logic [15:0] frac,
                                      logic [3:0] lim);
      command_type c;
      c = '{cmd, lvl, key, val, pos, frac, lim};
      return c;
   endfunction

   // Random keys come from a narrow band most of the time so that hits,
   // duplicates and removes of present keys are common.
   function automatic logic [31:0] pick_key(int l);
      if (shadow_count[l] != 0 && $urandom_range(0, 2) == 0)
         return shadow_key[l][$urandom_range(0, shadow_count[l] - 1)];
      if ($urandom_range(0, 3) == 0) return $urandom;
      return $signed($urandom_range(0, 63)) - 32;
   endfunction

   function automatic command_type random_command();
      command_type c;
      int r;
      c.lvl = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(0, 2));
      c.key = pick_key(c.lvl);
      c.val = {$urandom, $urandom};
      c.pos = (shadow_count[c.lvl] != 0 && $urandom_range(0, 1))
              ? 10'($urandom_range(0, shadow_count[c.lvl])) : 10'($urandom_range(0, 1023));
      c.frac = 16'($urandom);
      c.lim = 4'($urandom);
      r = $urandom_range(0, 99);
      if (r < 40) c.cmd = CMD_INSERT;
      else if (r < 52) c.cmd = CMD_LOOKUP;
      else if (r < 62) c.cmd = CMD_UPDATE;
      else if (r < 75) c.cmd = CMD_REMOVE;
      else if (r < 85) c.cmd = CMD_READ_POS;
      else if (r < 97) c.cmd = CMD_PICK;
      else if (r < 98) c.cmd = CMD_CLEAR;
      else c.cmd = CMD_UNUSED;
      return c;
   endfunction

   typedef struct packed {
      command_type c;
      bit fixed;
      answer_type a;
   } row_type;

   row_type directed [$];

   initial begin
      int wait_cycles;
      for (int i = 0; i < NLEV; i++) shadow_count[i] = 0;
      // Rows whose answer is obvious carry it; the rest use the predictor.
      directed = '{
         '{mk(CMD_PICK, 0, 0, 0, 0, 16'hFFFF, 4'hF), 1, '{STATUS_MISS, 0, 0, 0, 0}},
         '{mk(CMD_LOOKUP, 0, 0, 0, 0, 0, 0), 1, '{STATUS_MISS, 0, 0, 0, 0}},
         '{mk(CMD_REMOVE, 15, 32'h7FFFFFFF, 0, 0, 0, 0), 1, '{STATUS_DUP, 0, 0, 0, 0}},
         '{mk(CMD_READ_POS, 0, 0, 0, 10'h3FF, 0, 0), 1, '{STATUS_MISS, 0, 0, 0, 0}},
         '{mk(CMD_INSERT, 0, 32'h80000000, 64'hFFFFFFFFFFFFFFFF, 0, 0, 0), 1,
           '{STATUS_DONE, 0, 0, 0, 0}},
         '{mk(CMD_INSERT, 0, 32'h7FFFFFFF, 0, 0, 0, 0), 1, '{STATUS_DONE, 0, 0, 0, 0}},
         '{mk(CMD_INSERT, 0, 0, 64'h1234, 0, 0, 0), 1, '{STATUS_DONE, 0, 0, 0, 0}},
         '{mk(CMD_INSERT, 0, 0, 64'h5555, 0, 0, 0), 1, '{STATUS_DUP, 0, 0, 0, 0}},
         '{mk(CMD_READ_POS, 0, 0, 0, 0, 0, 0), 1,
           '{STATUS_DONE, 32'h80000000, 64'hFFFFFFFFFFFFFFFF, 0, 0}},
         '{mk(CMD_READ_POS, 0, 0, 0, 2, 0, 0), 1, '{STATUS_DONE, 32'h7FFFFFFF, 0, 0, 0}},
         '{mk(CMD_READ_POS, 0, 0, 0, 3, 0, 0), 1, '{STATUS_MISS, 0, 0, 0, 0}},
         '{mk(CMD_UPDATE, 0, 0, 64'hA5A5, 0, 0, 0), 0, '0},
         '{mk(CMD_LOOKUP, 0, 0, 0, 0, 0, 0), 1, '{STATUS_DONE, 0, 64'hA5A5, 0, 0}},
         '{mk(CMD_UPDATE, 0, 5, 0, 0, 0, 0), 1, '{STATUS_MISS, 0, 0, 0, 0}},
         '{mk(CMD_INSERT, 15, -7, 64'h77, 0, 0, 0), 0, '0},
         '{mk(CMD_PICK, 0, 0, 0, 0, 16'hFFFF, 4'hF), 0, '0},
         '{mk(CMD_PICK, 0, 0, 0, 0, 0, 4'hF), 0, '0},
         '{mk(CMD_PICK, 0, 0, 0, 0, 16'h8000, 0), 0, '0},
         '{mk(CMD_REMOVE, 0, 0, 0, 0, 0, 0), 1, '{STATUS_DONE, 0, 0, 0, 0}},
         '{mk(CMD_UNUSED, 0, 0, 0, 0, 0, 0), 1, '{STATUS_MISS, 0, 0, 0, 0}},
         '{mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0), 1, '{STATUS_DONE, 0, 0, 0, 0}},
         '{mk(CMD_PICK, 0, 0, 0, 0, 16'h1234, 4'hF), 1, '{STATUS_MISS, 0, 0, 0, 0}}
      };
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_command(directed[i].c, directed[i].fixed, directed[i].a);
      // Load one level while the receiver holds off, so the request side
      // backs up and the block stalls its input.
      hold_rsp = 1;
      for (int i = 0; i < 40; i++)
         send_command(mk(CMD_INSERT, 4, 32'(i * 3), 64'(i), 0, 0, 0), 0, '0);
      send_command(mk(CMD_INSERT, 4, 3, 0, 0, 0, 0), 1, '{STATUS_DUP, 0, 0, 0, 0});
      send_command(mk(CMD_REMOVE, 4, 0, 0, 0, 0, 0), 0, '0);
      send_command(mk(CMD_INSERT, 4, -1, 1, 0, 0, 0), 0, '0);
      send_command(mk(CMD_PICK, 0, 0, 0, 0, 16'hFFFF, 4'hF), 0, '0);
      send_command(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0), 0, '0);
      for (int i = 0; i < 380; i++) begin
         if (i > 330) quiet = 1;
         send_command(random_command(), 0, '0);
      end
      req_push <= 1'b0;
      wait_cycles = 0;
      while (pending_answers.size() != 0 && wait_cycles < 200000) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (100) @(negedge clock);
      if (mismatches == 0 && pending_answers.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule

### sim.f
hw/rtl/lskv_pkg.sv
hw/rtl/lskv_front.sv
hw/rtl/lskv_engine.sv
hw/rtl/leveled_sorted_key_value_table_core.sv
tb/sv/testbench.sv
